// ----- sv/assert_macros.svh -----
// assertion macros for the rtl file that carries checks
// depends on nothing; expects clk and rst_n in the including scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked out of reset
`define ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- sv/rlg_pkg.sv -----
// shared constants, types and elaboration-time trig tables for the gradient pixel unit
// no dependencies
package rlg_pkg;

    localparam int ANGLE_STEPS    = 90;
    localparam int QUAD_STEP      = 4;
    localparam int DEG_W          = $clog2(ANGLE_STEPS);
    localparam int TRIG_FRAC_BITS = 15;
    localparam int TRIG_W         = TRIG_FRAC_BITS + 1;
    localparam int TRIG_S_W       = TRIG_FRAC_BITS + 2;

    localparam int REG_DIM_W   = 12;
    localparam int DIAG_W      = 21;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 21;
    localparam int LEVEL_W     = 8;

    // quotient bits below the half-range saturation point of the ratio
    localparam int QUOT_BITS = 15;
    localparam int DIV_SHIFT = 23 - TRIG_FRAC_BITS;
    localparam logic [QUOT_BITS:0] QUOT_SAT = {1'b1, {QUOT_BITS{1'b0}}};

    localparam logic [CFG_INDEX_W-1:0] CFG_REGION_WIDTH  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_REGION_HEIGHT = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_DIAGONAL      = 2'd2;

    localparam logic [REG_DIM_W-1:0] WIDTH_RESET    = 12'd360;
    localparam logic [REG_DIM_W-1:0] HEIGHT_RESET   = 12'd140;
    localparam logic [DIAG_W-1:0]    DIAGONAL_RESET = 21'd98883;

    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
    localparam logic [63:0] ONE_Q30     = 64'd1 << 30;

    typedef logic [ANGLE_STEPS-1:0][TRIG_W-1:0] trig_table_t;

    // taylor series in q2.30, rounded to q1.15 and clamped to 0..1
    function automatic logic [TRIG_W-1:0] taylor_trig(input int unsigned rem,
                                                     input logic want_cos);
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] ts;
        logic [63:0] tc;
        logic [63:0] v;
        longint      acc_s;
        longint      acc_c;
        longint      acc;
        x     = (64'(rem) * HALF_PI_Q30) / 64'(ANGLE_STEPS);
        x2    = (x * x) >> 30;
        ts    = x;
        tc    = ONE_Q30;
        acc_s = longint'(x);
        acc_c = longint'(ONE_Q30);
        for (int n = 1; n <= 8; n++)
        begin
            ts = ((ts * x2) >> 30) / 64'((2 * n) * (2 * n + 1));
            tc = ((tc * x2) >> 30) / 64'((2 * n - 1) * (2 * n));
            if ((n & 1) != 0)
            begin
                acc_s = acc_s - longint'(ts);
                acc_c = acc_c - longint'(tc);
            end
            else
            begin
                acc_s = acc_s + longint'(ts);
                acc_c = acc_c + longint'(tc);
            end
        end
        acc = want_cos ? acc_c : acc_s;
        v   = (acc < 0) ? 64'd0 : 64'(acc);
        v   = (v + (64'd1 << (29 - TRIG_FRAC_BITS))) >> (30 - TRIG_FRAC_BITS);
        if (v > (64'd1 << TRIG_FRAC_BITS))
        begin
            v = 64'd1 << TRIG_FRAC_BITS;
        end
        return v[TRIG_W-1:0];
    endfunction

    function automatic trig_table_t build_table(input logic want_cos);
        trig_table_t tab;
        for (int r = 0; r < ANGLE_STEPS; r++)
        begin
            tab[r] = taylor_trig(r, want_cos);
        end
        return tab;
    endfunction

    localparam trig_table_t SIN_TABLE = build_table(1'b0);
    localparam trig_table_t COS_TABLE = build_table(1'b1);

endpackage

// ----- sv/rlg_angle.sv -----
// angle state kept as quadrant plus in-quadrant step, with signed sin/cos lookup
// depends on rlg_pkg for the trig tables
module rlg_angle import rlg_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       tick,
    output logic signed [TRIG_S_W-1:0] sin_val,
    output logic signed [TRIG_S_W-1:0] cos_val
);

    localparam int SUM_W = DEG_W + 1;

    localparam logic [1:0] QUAD_FIRST  = 2'd0;
    localparam logic [1:0] QUAD_SECOND = 2'd1;
    localparam logic [1:0] QUAD_THIRD  = 2'd2;
    localparam logic [1:0] QUAD_FOURTH = 2'd3;

    logic [1:0]       quad_reg;
    logic [1:0]       quad_next;
    logic [DEG_W-1:0] deg_reg;
    logic [DEG_W-1:0] deg_next;
    logic [SUM_W-1:0] deg_sum;
    logic [SUM_W-1:0] deg_wrapped;
    logic             wrap;

    logic signed [TRIG_S_W-1:0] s_pos;
    logic signed [TRIG_S_W-1:0] c_pos;

    assign deg_sum     = {1'b0, deg_reg} + SUM_W'(QUAD_STEP);
    assign wrap        = deg_sum >= SUM_W'(ANGLE_STEPS);
    assign deg_wrapped = deg_sum - SUM_W'(ANGLE_STEPS);

    always_comb
    begin
        quad_next = quad_reg;
        deg_next  = deg_reg;
        if (tick)
        begin
            if (wrap)
            begin
                quad_next = quad_reg + 2'd1;
                deg_next  = deg_wrapped[DEG_W-1:0];
            end
            else
            begin
                deg_next = deg_sum[DEG_W-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            quad_reg <= QUAD_FIRST;
            deg_reg  <= '0;
        end
        else
        begin
            quad_reg <= quad_next;
            deg_reg  <= deg_next;
        end
    end

    assign s_pos = $signed({1'b0, SIN_TABLE[deg_reg]});
    assign c_pos = $signed({1'b0, COS_TABLE[deg_reg]});

    // quadrant fold
    always_comb
    begin
        case (quad_reg)
            QUAD_FIRST:
            begin
                sin_val = s_pos;
                cos_val = c_pos;
            end
            QUAD_SECOND:
            begin
                sin_val = c_pos;
                cos_val = -s_pos;
            end
            QUAD_THIRD:
            begin
                sin_val = -s_pos;
                cos_val = -c_pos;
            end
            QUAD_FOURTH:
            begin
                sin_val = -c_pos;
                cos_val = s_pos;
            end
            default:
            begin
                sin_val = s_pos;
                cos_val = c_pos;
            end
        endcase
    end

endmodule

// ----- sv/rlg_div.sv -----
// iterative restoring divider, one quotient bit per cycle through one subtractor
// saturates at the half-range point; depends on rlg_pkg
module rlg_div import rlg_pkg::*;
#(
    parameter int MAG_W = 32
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [MAG_W-1:0]     mag,
    input  logic [DIAG_W-1:0]    den,
    output logic                 done,
    output logic [QUOT_BITS:0]   quotient
);

    localparam int LOW_BITS = QUOT_BITS - DIV_SHIFT;
    localparam int HI_W     = MAG_W - LOW_BITS;
    localparam int CNT_W    = $clog2(QUOT_BITS + 1);

    logic [HI_W-1:0]      hi;
    logic [QUOT_BITS-1:0] lo_init;
    logic                 overflow;

    logic [DIAG_W-1:0]    rem_reg;
    logic [QUOT_BITS-1:0] bits_reg;
    logic [DIAG_W-1:0]    den_reg;
    logic [CNT_W-1:0]     count_reg;
    logic                 busy_reg;
    logic                 sat_reg;
    logic                 done_reg;

    logic [DIAG_W:0]      trial;
    logic [DIAG_W:0]      diff;
    logic                 fits;

    // dividend is mag shifted up by DIV_SHIFT; high part sits above the quotient bits
    assign hi       = mag[MAG_W-1:LOW_BITS];
    assign lo_init  = {mag[LOW_BITS-1:0], {DIV_SHIFT{1'b0}}};
    assign overflow = hi >= HI_W'(den);

    assign trial = {rem_reg, bits_reg[QUOT_BITS-1]};
    assign diff  = trial - {1'b0, den_reg};
    assign fits  = !diff[DIAG_W];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            sat_reg   <= 1'b0;
            done_reg  <= 1'b0;
            count_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                if (overflow)
                begin
                    sat_reg  <= 1'b1;
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                begin
                    sat_reg   <= 1'b0;
                    busy_reg  <= 1'b1;
                    count_reg <= CNT_W'(QUOT_BITS);
                end
            end
            else if (busy_reg)
            begin
                count_reg <= count_reg - CNT_W'(1);
                if (count_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // datapath, no reset
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            den_reg  <= den;
            rem_reg  <= hi[DIAG_W-1:0];
            bits_reg <= lo_init;
        end
        else if (busy_reg)
        begin
            rem_reg  <= fits ? diff[DIAG_W-1:0] : trial[DIAG_W-1:0];
            bits_reg <= {bits_reg[QUOT_BITS-2:0], fits};
        end
    end

    assign done     = done_reg;
    assign quotient = sat_reg ? QUOT_SAT : {1'b0, bits_reg};

endmodule

// ----- sv/rotating_linear_gradient_pixel_unit.sv -----
// top level of the rotating linear gradient pixel unit: sequencer, shared multiplier,
// config registers and output register; uses rlg_pkg, rlg_angle, rlg_div, assert_macros.svh
//
// each request is a timer tick (command 0) or a pixel request (command 1) for a column
// and row inside the painted region; a tick turns the gradient angle by 4 degrees and
// gives no result, a pixel request gives one red/green/blue result; the pixel offset
// from the region centre is projected on the angle direction, scaled by the diagonal
// register (q.8, zero is taken as one), offset by one half, clamped to 0..1 and blended
// green->blue->red; a tick never raises in_stall, a pixel request keeps in_stall high
// through two passes through one multiplier, one accumulate, then a 15-step
// restoring divide through one subtractor (skipped when the ratio saturates), until
// its result is loaded; the next request is taken while a finished result still
// waits on out_stall; config writes are taken only while the unit is idle
`include "assert_macros.svh"
module rotating_linear_gradient_pixel_unit import rlg_pkg::*;
#(
    parameter int COORD_BITS = 12
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    // request channel
    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic                   command,
    input  logic [COORD_BITS-1:0]  column,
    input  logic [COORD_BITS-1:0]  row_index,
    // result channel
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic [LEVEL_W-1:0]     red_level,
    output logic [LEVEL_W-1:0]     green_level,
    output logic [LEVEL_W-1:0]     blue_level,
    // config write channel
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    // doubled offset 2*coord - dim needs room for both the coordinate and the dimension
    localparam int TX_W   = ((COORD_BITS + 1 > REG_DIM_W) ? COORD_BITS + 1 : REG_DIM_W) + 1;
    localparam int PROD_W = TX_W + TRIG_S_W;
    localparam int ACC_W  = PROD_W + 1;
    localparam int U_W    = QUOT_BITS + 2;
    localparam int SCL_W  = U_W + LEVEL_W;

    typedef enum logic [6:0] {
        ST_IDLE     = 7'b0000001,
        ST_MUL_X    = 7'b0000010,
        ST_MUL_Y    = 7'b0000100,
        ST_SUM      = 7'b0001000,
        ST_DIV_GO   = 7'b0010000,
        ST_DIV_WAIT = 7'b0100000,
        ST_DONE     = 7'b1000000
    } state_t;

    state_t state_reg;
    state_t state_next;

    // config registers
    logic [REG_DIM_W-1:0] width_reg;
    logic [REG_DIM_W-1:0] height_reg;
    logic [DIAG_W-1:0]    diag_reg;

    // operands latched at request accept
    logic signed [TX_W-1:0]     tx_reg;
    logic signed [TX_W-1:0]     ty_reg;
    logic signed [TX_W-1:0]     tx_new;
    logic signed [TX_W-1:0]     ty_new;
    logic signed [TRIG_S_W-1:0] sin_reg;
    logic signed [TRIG_S_W-1:0] cos_reg;
    logic signed [TRIG_S_W-1:0] sin_val;
    logic signed [TRIG_S_W-1:0] cos_val;

    // shared multiplier and accumulator
    logic signed [TX_W-1:0]     mul_a;
    logic signed [TRIG_S_W-1:0] mul_b;
    logic signed [PROD_W-1:0]   mul_p;
    logic signed [PROD_W-1:0]   prod_reg;
    logic signed [ACC_W-1:0]    acc_reg;
    logic [ACC_W-1:0]           mag;
    logic                       neg;
    logic [DIAG_W-1:0]          den;

    logic                       div_start;
    logic                       div_done;
    logic [QUOT_BITS:0]         div_quot;

    // colour blend
    logic [U_W-1:0]             u_up;
    logic [U_W-1:0]             u_down;
    logic [SCL_W-1:0]           scl_up;
    logic [SCL_W-1:0]           scl_down;
    logic [LEVEL_W-1:0]         level_up;
    logic [LEVEL_W-1:0]         level_down;

    // output register
    logic                       out_valid_reg;
    logic [LEVEL_W-1:0]         red_reg;
    logic [LEVEL_W-1:0]         green_reg;
    logic [LEVEL_W-1:0]         blue_reg;

    logic in_take;
    logic pixel_take;
    logic tick_take;
    logic cfg_take;
    logic out_free;
    logic out_load;

    // handshakes
    assign in_stall   = (state_reg != ST_IDLE);
    assign cfg_ready  = (state_reg == ST_IDLE);
    assign in_take    = in_valid && !in_stall;
    assign pixel_take = in_take && command;
    assign tick_take  = in_take && !command;
    assign cfg_take   = cfg_valid && cfg_ready;
    assign out_free   = !out_valid_reg || !out_stall;
    assign out_load   = (state_reg == ST_DONE) && out_free;

    // config writes, unknown indexes dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= WIDTH_RESET;
            height_reg <= HEIGHT_RESET;
            diag_reg   <= DIAGONAL_RESET;
        end
        else if (cfg_take)
        begin
            unique case (cfg_index)
                CFG_REGION_WIDTH:  width_reg  <= cfg_data[REG_DIM_W-1:0];
                CFG_REGION_HEIGHT: height_reg <= cfg_data[REG_DIM_W-1:0];
                CFG_DIAGONAL:      diag_reg   <= cfg_data[DIAG_W-1:0];
                default:           ;
            endcase
        end
    end

    // angle state advances on a tick
    rlg_angle u_angle (
        .clk     (clk),
        .rst_n   (rst_n),
        .tick    (tick_take),
        .sin_val (sin_val),
        .cos_val (cos_val)
    );

    // centre offsets, doubled so the half pixel stays exact
    assign tx_new = $signed(TX_W'({column, 1'b0})) - $signed(TX_W'(width_reg));
    assign ty_new = $signed(TX_W'({row_index, 1'b0})) - $signed(TX_W'(height_reg));

    // one multiplier: x term in ST_MUL_X, y term in ST_MUL_Y
    assign mul_a = (state_reg == ST_MUL_X) ? tx_reg : ty_reg;
    assign mul_b = (state_reg == ST_MUL_X) ? cos_reg : sin_reg;
    assign mul_p = mul_a * mul_b;

    always_ff @(posedge clk)
    begin
        if (pixel_take)
        begin
            tx_reg  <= tx_new;
            ty_reg  <= ty_new;
            sin_reg <= sin_val;
            cos_reg <= cos_val;
        end
        if ((state_reg == ST_MUL_X) || (state_reg == ST_MUL_Y))
        begin
            prod_reg <= mul_p;
        end
        // x product lands in the accumulator while the y product is formed
        if (state_reg == ST_MUL_Y)
        begin
            acc_reg <= {prod_reg[PROD_W-1], prod_reg};
        end
        else if (state_reg == ST_SUM)
        begin
            acc_reg <= acc_reg + {prod_reg[PROD_W-1], prod_reg};
        end
    end

    // projection magnitude and sign for the divider
    assign neg       = acc_reg[ACC_W-1];
    assign mag       = neg ? ACC_W'(-acc_reg) : ACC_W'(acc_reg);
    assign den       = (diag_reg == '0) ? DIAG_W'(1) : diag_reg;
    assign div_start = (state_reg == ST_DIV_GO);

    rlg_div #(
        .MAG_W (ACC_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .mag      (mag),
        .den      (den),
        .done     (div_done),
        .quotient (div_quot)
    );

    // blend: u is the distance from the centre colour in q1.16, 0..1 inclusive
    // level = floor(255 * u / 65536), with 255 * u as a shift and subtract
    assign u_up       = {div_quot, 1'b0};
    assign u_down     = {1'b1, {(U_W - 1){1'b0}}} - u_up;
    assign scl_up     = {u_up, {LEVEL_W{1'b0}}} - SCL_W'(u_up);
    assign scl_down   = {u_down, {LEVEL_W{1'b0}}} - SCL_W'(u_down);
    assign level_up   = scl_up[U_W-1 +: LEVEL_W];
    assign level_down = scl_down[U_W-1 +: LEVEL_W];

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (pixel_take)
                begin
                    state_next = ST_MUL_X;
                end
            end
            ST_MUL_X:    state_next = ST_MUL_Y;
            ST_MUL_Y:    state_next = ST_SUM;
            ST_SUM:      state_next = ST_DIV_GO;
            ST_DIV_GO:   state_next = ST_DIV_WAIT;
            ST_DIV_WAIT:
            begin
                if (div_done)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                // hold the finished pixel until the output register frees up
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:     state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // negative side blends green to blue, positive side blue to red
    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            red_reg   <= neg ? '0 : level_up;
            green_reg <= neg ? level_up : '0;
            blue_reg  <= level_down;
        end
    end

    assign out_valid   = out_valid_reg;
    assign red_level   = red_reg;
    assign green_level = green_reg;
    assign blue_level  = blue_reg;

    // checks
    `ASSERT_NEXT(a_pixel_starts_mul, pixel_take, state_reg == ST_MUL_X, "no multiply start")
    `ASSERT_IMPLY(a_div_done_in_wait, div_done, state_reg == ST_DIV_WAIT, "stray divider done")
    `ASSERT_IMPLY(a_quot_range, div_done, div_quot <= QUOT_SAT, "quotient above saturation")
    `ASSERT_NEXT(a_load_sets_valid, out_load, out_valid_reg && state_reg == ST_IDLE, "no result")

endmodule

// ----- verif/tb_top.sv -----
`timescale 1ns / 1ps
// self-checking bench for rotating_linear_gradient_pixel_unit: directed and random ticks and
// pixel requests, colors predicted in the bench; depends on rlg_pkg and the unit's rtl
module tb_top;
    import rlg_pkg::*;

    // command codes on the request channel
    localparam logic CMD_TICK  = 1'b0;
    localparam logic CMD_PIXEL = 1'b1;
    // config index past the last register, the unit must ignore it
    localparam logic [CFG_INDEX_W-1:0] CFG_SPARE = 2'd3;

    localparam int COORD_W       = 12;
    localparam int COORD_MAX     = 4094;
    localparam int CYCLE_LIMIT   = 600000;
    localparam int SETTLE_CYCLES = 64;

    typedef struct packed {
        logic               cmd;
        logic [COORD_W-1:0] col;
        logic [COORD_W-1:0] row;
    } request_t;

    typedef struct packed {
        logic [LEVEL_W-1:0] red;
        logic [LEVEL_W-1:0] green;
        logic [LEVEL_W-1:0] blue;
    } color_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    // every input of the unit starts at a known value
    logic                   in_valid  = 1'b0;
    logic                   command   = CMD_TICK;
    logic [COORD_W-1:0]     column    = '0;
    logic [COORD_W-1:0]     row_index = '0;
    logic                   out_stall = 1'b0;
    logic                   cfg_valid = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data  = '0;

    logic               in_stall;
    logic               out_valid;
    logic [LEVEL_W-1:0] red_level;
    logic [LEVEL_W-1:0] green_level;
    logic [LEVEL_W-1:0] blue_level;
    logic               cfg_ready;

    rotating_linear_gradient_pixel_unit DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .command     (command),
        .column      (column),
        .row_index   (row_index),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .red_level   (red_level),
        .green_level (green_level),
        .blue_level  (blue_level),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    // bench copy of the unit's state and registers
    int unsigned gradient_angle = 0;
    int unsigned shadow_width   = 360;
    int unsigned shadow_height  = 140;
    int unsigned shadow_diag    = 98883;

    // in-quadrant sine and cosine in q1.15, indexed by the remainder step
    longint unsigned quarter_sin [ANGLE_STEPS];
    longint unsigned quarter_cos [ANGLE_STEPS];

    request_t request_q [$];
    color_t   pending_colors [$];
    request_t on_wire;
    int       unsent         = 0;   // requests queued but not yet taken by the unit
    int       send_gap       = 0;
    int       recv_hold      = 0;
    int       mismatch_count = 0;
    int       cycle_count    = 0;
    bit       idle_enable    = 1'b1;

    initial
    begin
        forever #5 clk = ~clk;
    end

    // hard stop if the unit hangs
    always @(posedge clk)
    begin
        cycle_count = cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // q2.30 accumulator rounded half up to q1.15, clamped to 0..1
    function automatic longint unsigned round_q15(input longint acc);
        longint unsigned v;
        v = (acc < 0) ? 64'd0 : 64'(acc);
        v = (v + (64'd1 << (29 - TRIG_FRAC_BITS))) >> (30 - TRIG_FRAC_BITS);
        if (v > (64'd1 << TRIG_FRAC_BITS))
        begin
            v = 64'd1 << TRIG_FRAC_BITS;
        end
        return v;
    endfunction

    // nine-term taylor series per remainder step, built once at time zero
    initial
    begin : trig_build
        longint unsigned x;
        longint unsigned x2;
        longint unsigned ts;
        longint unsigned tc;
        longint          acc_s;
        longint          acc_c;
        for (int r = 0; r < ANGLE_STEPS; r++)
        begin
            x     = (64'(r) * HALF_PI_Q30) / 64'(ANGLE_STEPS);
            x2    = (x * x) >> 30;
            ts    = x;
            tc    = ONE_Q30;
            acc_s = longint'(x);
            acc_c = longint'(ONE_Q30);
            for (int n = 1; n <= 8; n++)
            begin
                ts = ((ts * x2) >> 30) / 64'((2 * n) * (2 * n + 1));
                tc = ((tc * x2) >> 30) / 64'((2 * n - 1) * (2 * n));
                if (n % 2 == 1)
                begin
                    acc_s = acc_s - longint'(ts);
                    acc_c = acc_c - longint'(tc);
                end
                else
                begin
                    acc_s = acc_s + longint'(ts);
                    acc_c = acc_c + longint'(tc);
                end
            end
            quarter_sin[r] = round_q15(acc_s);
            quarter_cos[r] = round_q15(acc_c);
        end
    end

    // color of one pixel at the current angle and register values
    function automatic color_t gradient_color(input logic [COORD_W-1:0] col,
                                              input logic [COORD_W-1:0] row);
        int unsigned     quad;
        int unsigned     rem;
        longint          s;
        longint          c;
        longint          sn;
        longint          cs;
        longint          tx;
        longint          ty;
        longint          num;
        longint          ratio;
        longint unsigned mag;
        longint unsigned den;
        longint unsigned q;
        longint unsigned t;
        color_t          rgb;
        quad = (4 * gradient_angle) / ANGLE_STEPS;
        rem  = 4 * gradient_angle - quad * ANGLE_STEPS;
        s    = longint'(quarter_sin[rem]);
        c    = longint'(quarter_cos[rem]);
        // fold the in-quadrant values out to the full circle
        case (quad)
            0:       begin sn = s;  cs = c;  end
            1:       begin sn = c;  cs = -s; end
            2:       begin sn = -s; cs = -c; end
            default: begin sn = -c; cs = s;  end
        endcase
        // doubled offset from the centre keeps odd sizes exact
        tx  = 2 * longint'(col) - longint'(shadow_width);
        ty  = 2 * longint'(row) - longint'(shadow_height);
        num = tx * cs + ty * sn;
        mag = (num < 0) ? -num : num;
        // a zero diagonal is taken as one
        den = ((shadow_diag == 0) ? 64'd1 : 64'(shadow_diag)) << TRIG_FRAC_BITS;
        q   = (mag << 23) / den;
        if (q > 64'd65536)
        begin
            q = 64'd65536;
        end
        ratio = (num < 0) ? 32768 - longint'(q) : 32768 + longint'(q);
        if (ratio < 0)
        begin
            ratio = 0;
        end
        if (ratio > 65536)
        begin
            ratio = 65536;
        end
        // green to blue below one half, blue to red from one half up
        if (ratio < 32768)
        begin
            t         = 2 * ratio;
            rgb.red   = '0;
            rgb.green = LEVEL_W'((64'd255 * (64'd65536 - t)) >> 16);
            rgb.blue  = LEVEL_W'((64'd255 * t) >> 16);
        end
        else
        begin
            t         = 2 * (ratio - 32768);
            rgb.red   = LEVEL_W'((64'd255 * t) >> 16);
            rgb.green = '0;
            rgb.blue  = LEVEL_W'((64'd255 * (64'd65536 - t)) >> 16);
        end
        return rgb;
    endfunction

    task automatic flag_mismatch(input string what, input int got, input int want);
        mismatch_count = mismatch_count + 1;
        $display("mismatch %0s: got %0d, wanted %0d (cycle %0d)",
                 what, got, want, cycle_count);
    endtask

    // request driver: takes the next request from the queue, holds it while stalled,
    // and predicts each request at the edge where the unit takes it
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid  <= 1'b0;
            command   <= CMD_TICK;
            column    <= '0;
            row_index <= '0;
            send_gap  = 0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                if (on_wire.cmd == CMD_PIXEL)
                begin
                    pending_colors.push_back(gradient_color(on_wire.col, on_wire.row));
                end
                else
                begin
                    // a tick at the last step wraps back to angle zero
                    gradient_angle = (gradient_angle + 1) % ANGLE_STEPS;
                end
                unsent = unsent - 1;
                // idle burst before the next request
                if (idle_enable && $urandom_range(0, 2) == 0)
                begin
                    send_gap = $urandom_range(1, 16);
                end
            end
            // a stalled request stays on the wire unchanged
            if (!(in_valid && in_stall))
            begin
                if (send_gap > 0)
                begin
                    send_gap = send_gap - 1;
                    in_valid <= 1'b0;
                end
                else if (request_q.size() != 0)
                begin
                    on_wire = request_q.pop_front();
                    in_valid  <= 1'b1;
                    command   <= on_wire.cmd;
                    column    <= on_wire.col;
                    row_index <= on_wire.row;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // result monitor: random stall bursts, each taken result checked against the oldest
    // predicted color
    always @(posedge clk or negedge rst_n)
    begin
        color_t want;
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            recv_hold = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (pending_colors.size() == 0)
                begin
                    flag_mismatch("result with no pixel request", int'(red_level), 0);
                end
                else
                begin
                    want = pending_colors.pop_front();
                    if (red_level !== want.red)
                    begin
                        flag_mismatch("red_level", int'(red_level), int'(want.red));
                    end
                    if (green_level !== want.green)
                    begin
                        flag_mismatch("green_level", int'(green_level), int'(want.green));
                    end
                    if (blue_level !== want.blue)
                    begin
                        flag_mismatch("blue_level", int'(blue_level), int'(want.blue));
                    end
                end
            end
            if (recv_hold > 0)
            begin
                recv_hold = recv_hold - 1;
                out_stall <= 1'b1;
            end
            else if (idle_enable && !out_stall && $urandom_range(0, 5) == 0)
            begin
                recv_hold = $urandom_range(1, 16) - 1;
                out_stall <= 1'b1;
            end
            else
            begin
                out_stall <= 1'b0;
            end
        end
    end

    task automatic push_request(input logic cmd, input int unsigned col, input int unsigned row);
        request_t req;
        req.cmd = cmd;
        req.col = COORD_W'(col);
        req.row = COORD_W'(row);
        request_q.push_back(req);
        unsent = unsent + 1;
    endtask

    // one register write; only called while the unit is idle
    task automatic write_register(input logic [CFG_INDEX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] data);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
        begin
            @(posedge clk);
        end
        while (!cfg_ready);
        case (idx)
            CFG_REGION_WIDTH:  shadow_width  = int'(data[REG_DIM_W-1:0]);
            CFG_REGION_HEIGHT: shadow_height = int'(data[REG_DIM_W-1:0]);
            CFG_DIAGONAL:      shadow_diag   = int'(data[DIAG_W-1:0]);
            default:           ;
        endcase
        cfg_valid <= 1'b0;
    endtask

    // sender holds off until every request is taken and every color has come back,
    // then lets the unit finish whatever is in flight
    task automatic wait_drained();
        while (unsent != 0 || pending_colors.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // random mix: about a third ticks, pixels mostly inside the region
    task automatic add_random(input int count);
        int unsigned span_w;
        int unsigned span_h;
        span_w = (shadow_width == 0) ? 1 : shadow_width;
        span_h = (shadow_height == 0) ? 1 : shadow_height;
        for (int i = 0; i < count; i++)
        begin
            if ($urandom_range(0, 9) < 3)
            begin
                push_request(CMD_TICK, $urandom_range(0, COORD_MAX), $urandom_range(0, COORD_MAX));
            end
            else if ($urandom_range(0, 3) != 0)
            begin
                push_request(CMD_PIXEL, $urandom_range(0, span_w - 1),
                             $urandom_range(0, span_h - 1));
            end
            else
            begin
                push_request(CMD_PIXEL, $urandom_range(0, COORD_MAX),
                             $urandom_range(0, COORD_MAX));
            end
        end
    endtask

    initial
    begin
        int unsigned w;
        int unsigned h;
        int unsigned d;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset register values: centre, corners, far coordinates
        push_request(CMD_PIXEL, 180, 70);     // centre, ratio exactly one half
        push_request(CMD_PIXEL, 0, 0);
        push_request(CMD_PIXEL, 359, 139);
        push_request(CMD_PIXEL, COORD_MAX, COORD_MAX);
        push_request(CMD_PIXEL, 0, COORD_MAX);
        push_request(CMD_PIXEL, COORD_MAX, 0);
        push_request(CMD_TICK, COORD_MAX, COORD_MAX);
        push_request(CMD_PIXEL, 359, 70);
        push_request(CMD_TICK, 0, 0);
        push_request(CMD_PIXEL, 0, 70);
        wait_drained();

        // largest region and diagonal
        write_register(CFG_REGION_WIDTH, 21'd4095);
        write_register(CFG_REGION_HEIGHT, 21'd4095);
        write_register(CFG_DIAGONAL, 21'd1483000);
        push_request(CMD_PIXEL, 0, 0);
        push_request(CMD_PIXEL, COORD_MAX, COORD_MAX);
        push_request(CMD_PIXEL, 2047, 2047);
        wait_drained();

        // smallest region and diagonal, the ratio saturates almost everywhere
        write_register(CFG_REGION_WIDTH, 21'd1);
        write_register(CFG_REGION_HEIGHT, 21'd1);
        write_register(CFG_DIAGONAL, 21'd1);
        push_request(CMD_PIXEL, 0, 0);
        push_request(CMD_PIXEL, COORD_MAX, COORD_MAX);
        wait_drained();

        // zero diagonal, zero width and height, and a write to the spare index
        write_register(CFG_DIAGONAL, 21'd0);
        write_register(CFG_REGION_WIDTH, 21'd0);
        write_register(CFG_REGION_HEIGHT, 21'd0);
        write_register(CFG_SPARE, CFG_DATA_W'($urandom));
        push_request(CMD_PIXEL, 0, 0);
        push_request(CMD_PIXEL, COORD_MAX, 0);
        push_request(CMD_PIXEL, 0, COORD_MAX);
        wait_drained();

        // random traffic at the reset register values
        write_register(CFG_REGION_WIDTH, CFG_DATA_W'(WIDTH_RESET));
        write_register(CFG_REGION_HEIGHT, CFG_DATA_W'(HEIGHT_RESET));
        write_register(CFG_DIAGONAL, CFG_DATA_W'(DIAGONAL_RESET));
        add_random(300);
        wait_drained();

        // random regions; junk above the 12 size bits must be dropped
        for (int k = 0; k < 4; k++)
        begin
            w = ($urandom_range(0, 1) == 0) ? $urandom_range(1, 400) : $urandom_range(1, 4095);
            h = ($urandom_range(0, 1) == 0) ? $urandom_range(1, 400) : $urandom_range(1, 4095);
            if ($urandom_range(0, 9) < 7)
            begin
                d = $rtoi($sqrt(real'(w * w + h * h)) * 256.0 + 0.5);
            end
            else
            begin
                d = $urandom_range(1, 1483000);
            end
            write_register(CFG_REGION_WIDTH, {9'($urandom), 12'(w)});
            write_register(CFG_REGION_HEIGHT, {9'($urandom), 12'(h)});
            write_register(CFG_DIAGONAL, CFG_DATA_W'(d));
            if ($urandom_range(0, 1) == 0)
            begin
                write_register(CFG_SPARE, CFG_DATA_W'($urandom));
            end
            // one phase runs at full rate on both sides
            idle_enable = (k != 2);
            add_random(250);
            wait_drained();
        end

        // closing stretch: no idling on either side
        idle_enable = 1'b0;
        write_register(CFG_REGION_WIDTH, CFG_DATA_W'(WIDTH_RESET));
        write_register(CFG_REGION_HEIGHT, CFG_DATA_W'(HEIGHT_RESET));
        write_register(CFG_DIAGONAL, CFG_DATA_W'(DIAGONAL_RESET));
        add_random(200);
        wait_drained();

        if (mismatch_count == 0)
        begin
            $display("CHECK OK");
        end
        else
        begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
